### rtl/sbda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbda_pkg: shared types and constants for the signed binary to decimal ASCII block
// Character codes, the back-end state type and the request queue depth.
// ----------------------------------------------------------------------------
package sbda_pkg;

    // Output character width and codes
    localparam int CHAR_W = 6;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;

    // One BCD digit
    localparam int BCD_W = 4;

    // Request queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Back-end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_DIGITS
    } t_back_state;

    // Handshake between queue head and back end
    typedef struct packed {
        logic valid;
        logic neg;
    } t_q_head;

endpackage

### rtl/sbda_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbda_front: request intake and sign/magnitude split
// Accepts a signed value, splits it into sign and unsigned magnitude and
// holds it in a small queue until the back end takes it.
// ----------------------------------------------------------------------------
module sbda_front
    import sbda_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                          o_stall,
    output t_q_head                       o_head,
    output logic [VALUE_WIDTH-1:0]        o_head_mag,
    input  logic                          i_pop
);

    logic [VALUE_WIDTH-1:0] r_mag [Q_DEPTH];
    logic                   r_neg [Q_DEPTH];
    logic [Q_AW-1:0]        r_wptr, n_wptr;
    logic [Q_AW-1:0]        r_rptr, n_rptr;
    logic [Q_AW:0]          r_count, n_count;

    logic [VALUE_WIDTH-1:0] v_raw;
    logic                   v_neg;
    logic [VALUE_WIDTH-1:0] v_mag;
    logic                   push;
    logic                   pop;

    // Sign and magnitude; the most negative value maps to 2^(W-1) unsigned
    assign v_raw = i_value;
    assign v_neg = v_raw[VALUE_WIDTH-1];
    assign v_mag = v_neg ? (~v_raw + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : v_raw;

    // Queue handshake
    assign o_stall = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign push    = i_valid && !o_stall;
    assign pop     = i_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.neg   = r_neg[r_rptr];
    assign o_head_mag   = r_mag[r_rptr];

    // Pointer and count update
    always_comb begin
        n_wptr  = push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = pop  ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Queue storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mag[r_wptr] <= v_mag;
            r_neg[r_wptr] <= v_neg;
        end
    end

endmodule

### rtl/sbda_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbda_back: binary to BCD conversion and character emitter
// Shift-and-add-3 conversion, one magnitude bit per cycle, then walks the
// BCD digits from the top, dropping leading zeros, into an output register.
// ----------------------------------------------------------------------------
module sbda_back
    import sbda_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_q_head                i_head,
    input  logic [VALUE_WIDTH-1:0] i_head_mag,
    output logic                   o_pop,
    output logic                   o_valid,
    output logic [CHAR_W-1:0]      o_character,
    output logic                   o_last_char,
    input  logic                   i_stall
);

    // Decimal digits enough for any VALUE_WIDTH-bit unsigned value
    localparam int ND  = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BW  = ND * BCD_W;
    localparam int SW  = $clog2(VALUE_WIDTH + 1);
    localparam int IW  = $clog2(ND);

    t_back_state            r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_bin, n_bin;
    logic [BW-1:0]          r_bcd, n_bcd;
    logic [SW-1:0]          r_step, n_step;
    logic [IW-1:0]          r_idx, n_idx;
    logic                   r_neg, n_neg;
    logic                   r_started, n_started;
    logic                   r_ovalid, n_ovalid;
    logic [CHAR_W-1:0]      r_char, n_char;
    logic                   r_last, n_last;

    logic [BW-1:0]          bcd_adj;
    logic [BCD_W-1:0]       top_digit;
    logic                   out_free;
    logic                   skip;
    logic                   load;

    // Add 3 to every digit of 5 or more ahead of the shift
    always_comb begin
        for (int d = 0; d < ND; d++) begin
            if (r_bcd[d*BCD_W +: BCD_W] >= 4'd5) begin
                bcd_adj[d*BCD_W +: BCD_W] = r_bcd[d*BCD_W +: BCD_W] + 4'd3;
            end else begin
                bcd_adj[d*BCD_W +: BCD_W] = r_bcd[d*BCD_W +: BCD_W];
            end
        end
    end

    assign top_digit = r_bcd[BW-1 -: BCD_W];
    assign out_free  = !r_ovalid || !i_stall;
    assign skip      = !r_started && (top_digit == '0) && (r_idx != '0);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_head.valid) n_state = ST_CONV;
            end
            ST_CONV: begin
                if (r_step == SW'(1)) n_state = r_neg ? ST_SIGN : ST_DIGITS;
            end
            ST_SIGN: begin
                if (out_free) n_state = ST_DIGITS;
            end
            ST_DIGITS: begin
                if (!skip && out_free && (r_idx == '0)) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        o_pop     = 1'b0;
        n_bin     = r_bin;
        n_bcd     = r_bcd;
        n_step    = r_step;
        n_idx     = r_idx;
        n_neg     = r_neg;
        n_started = r_started;
        load      = 1'b0;
        n_char    = r_char;
        n_last    = r_last;
        case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop  = 1'b1;
                    n_bin  = i_head_mag;
                    n_neg  = i_head.neg;
                    n_bcd  = '0;
                    n_step = SW'(VALUE_WIDTH);
                end
            end
            ST_CONV: begin
                n_bcd     = {bcd_adj[BW-2:0], r_bin[VALUE_WIDTH-1]};
                n_bin     = r_bin << 1;
                n_step    = r_step - 1'b1;
                n_idx     = IW'(ND - 1);
                n_started = 1'b0;
            end
            ST_SIGN: begin
                if (out_free) begin
                    load   = 1'b1;
                    n_char = CHAR_MINUS;
                    n_last = 1'b0;
                end
            end
            ST_DIGITS: begin
                if (skip) begin
                    n_bcd = r_bcd << BCD_W;
                    n_idx = r_idx - 1'b1;
                end else if (out_free) begin
                    load      = 1'b1;
                    n_char    = CHAR_ZERO + {{(CHAR_W-BCD_W){1'b0}}, top_digit};
                    n_last    = (r_idx == '0);
                    n_started = 1'b1;
                    n_bcd     = r_bcd << BCD_W;
                    n_idx     = r_idx - 1'b1;
                end
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
        // Output register holds until taken
        if (load) begin
            n_ovalid = 1'b1;
        end else if (!i_stall) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_bin     <= n_bin;
        r_bcd     <= n_bcd;
        r_step    <= n_step;
        r_idx     <= n_idx;
        r_neg     <= n_neg;
        r_started <= n_started;
        r_char    <= n_char;
        r_last    <= n_last;
    end

    assign o_valid     = r_ovalid;
    assign o_character = r_char;
    assign o_last_char = r_last;

endmodule

### rtl/signed_binary_to_decimal_ascii_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_top: signed integer to decimal text
// Converts a signed two's complement value to ASCII decimal characters.
// ----------------------------------------------------------------------------
// Each accepted value yields its decimal text one character per output
// request, most significant first: a '-' for negative values, then the digits
// with leading zeros removed (zero gives a single '0'); o_last_char marks the
// final digit. The most negative value prints in full. A two-entry queue
// decouples intake from conversion, so up to two values can wait while one is
// printed. The back end handles one value at a time: it takes the value from
// the queue, runs the shift-and-add-3 conversion over the magnitude bits,
// emits a minus sign when negative and walks the ND BCD digits (ND =
// floor(VALUE_WIDTH*log10 2) + 1); sign and digits wait while output stalls.
module signed_binary_to_decimal_ascii_top
    import sbda_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                          o_stall,
    output logic                          o_valid,
    output logic [CHAR_W-1:0]             o_character,
    output logic                          o_last_char,
    input  logic                          i_stall
);

    t_q_head                q_head;
    logic [VALUE_WIDTH-1:0] q_mag;
    logic                   q_pop;

    // Intake and queue
    sbda_front #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_value    (i_value),
        .o_stall    (o_stall),
        .o_head     (q_head),
        .o_head_mag (q_mag),
        .i_pop      (q_pop)
    );

    // Conversion and character output
    sbda_back #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .i_head_mag  (q_mag),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .o_character (o_character),
        .o_last_char (o_last_char),
        .i_stall     (i_stall)
    );

endmodule

### rtl/sbda_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbda_checker: port-level checks for the decimal ASCII converter
// Watches the output channel for legal character sequences.
// ----------------------------------------------------------------------------
module sbda_checker
    import sbda_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic [CHAR_W-1:0] o_character,
    input logic              o_last_char,
    input logic              i_stall
);

    logic r_after_minus;
    logic r_in_number;
    logic out_take;

    assign out_take = o_valid && !i_stall;

    // Track position inside the current number
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_minus <= 1'b0;
            r_in_number   <= 1'b0;
        end else if (out_take) begin
            r_after_minus <= (o_character == CHAR_MINUS);
            r_in_number   <= !o_last_char;
        end
    end

    // Stalled output holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_character) && $stable(o_last_char))
        else $error("output changed while stalled");

    // Only '-' or a digit appears
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_character == CHAR_MINUS) ||
                    ((o_character >= CHAR_ZERO) && (o_character <= CHAR_NINE)))
        else $error("illegal character code");

    // A minus sign never ends a number and only opens one
    a_minus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_character == CHAR_MINUS) |-> !o_last_char && !r_in_number)
        else $error("minus sign out of place");

    // First digit after a minus sign is never zero
    a_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_after_minus |-> (o_character != CHAR_MINUS) &&
                                     (o_character != CHAR_ZERO))
        else $error("bad first digit of negative number");

endmodule

bind signed_binary_to_decimal_ascii_top sbda_checker u_sbda_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .o_character (o_character),
    .o_last_char (o_last_char),
    .i_stall     (i_stall)
);

### tb/sbda_text_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbda_text_checker: decimal text predictor and scoreboard
// Watches the value and character channels of the converter, builds the
// expected character string for each accepted value and compares every
// accepted character, in order, against it.
// ----------------------------------------------------------------------------
module sbda_text_checker
    import sbda_pkg::*;
#(
    parameter int VW = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // value request channel
    input  logic                 i_req_valid,
    input  logic                 i_req_stall,
    input  logic signed [VW-1:0] i_req_value,
    // character request channel
    input  logic                 i_rsp_valid,
    input  logic                 i_rsp_stall,
    input  logic [CHAR_W-1:0]    i_rsp_character,
    input  logic                 i_rsp_last_char,
    // status to the top
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_chars_checked
);

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_text_char;

    t_text_char text_q[$];
    int         err_count  = 0;
    int         pend_count = 0;
    int         char_count = 0;

    assign o_errors        = err_count;
    assign o_pending       = pend_count;
    assign o_chars_checked = char_count;

    task automatic report_mismatch(input string what);
        $display("%0t ns checker: %s", $time, what);
        err_count++;
    endtask

    // Append the decimal text of one value: optional minus, then digits MSD first
    function automatic void queue_decimal_text(input logic signed [VW-1:0] v);
        logic [VW:0] mag;
        logic [3:0]  digs [0:23];
        int          nd;
        t_text_char  tc;
        // one bit wider so the most negative value does not overflow
        mag = v[VW-1] ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
        nd  = 0;
        do begin
            digs[nd] = 4'(mag % 10);
            mag      = mag / 10;
            nd++;
        end while (mag != 0);
        if (v[VW-1]) begin
            tc.code = CHAR_MINUS;
            tc.last = 1'b0;
            text_q.push_back(tc);
        end
        for (int k = nd - 1; k >= 0; k--) begin
            tc.code = CHAR_ZERO + CHAR_W'(digs[k]);
            tc.last = (k == 0);
            text_q.push_back(tc);
        end
    endfunction

    // Compare accepted characters first, then predict for an accepted value
    always @(posedge i_clk) begin
        t_text_char exp_c;
        if (!i_rst_n) begin
            text_q.delete();
        end else begin
            if (i_rsp_valid && !i_rsp_stall) begin
                char_count++;
                if (text_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                              i_rsp_character, i_rsp_last_char));
                end else begin
                    exp_c = text_q.pop_front();
                    if (i_rsp_character !== exp_c.code)
                        report_mismatch($sformatf("character got %0d expected %0d",
                                                  i_rsp_character, exp_c.code));
                    if (i_rsp_last_char !== exp_c.last)
                        report_mismatch($sformatf("last_char got %b expected %b (char %0d)",
                                                  i_rsp_last_char, exp_c.last, exp_c.code));
                end
            end
            if (i_req_valid && !i_req_stall)
                queue_decimal_text(i_req_value);
        end
        pend_count = text_q.size();
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: signed binary to decimal ASCII converter test
// Drives directed and random signed values with random idle and stall gaps,
// and lets the checker score every character; prints the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import sbda_pkg::*;

    localparam int VW        = 32;
    localparam int CYC_LIMIT = 400000;
    localparam int N_RANDOM  = 350;
    localparam int DRAIN_CYC = 60;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic signed [VW-1:0] i_value;
    logic                 o_stall;
    logic                 o_valid;
    logic [CHAR_W-1:0]    o_character;
    logic                 o_last_char;
    logic                 i_stall;

    int errors;
    int pending;
    int chars_checked;
    int cycles;
    int n_sent;
    int n_neg;
    int n_zero;
    bit no_idle;

    signed_binary_to_decimal_ascii_top #(.VALUE_WIDTH(VW)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_value     (i_value),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_character (o_character),
        .o_last_char (o_last_char),
        .i_stall     (i_stall)
    );

    sbda_text_checker #(.VW(VW)) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_valid),
        .i_req_stall     (o_stall),
        .i_req_value     (i_value),
        .i_rsp_valid     (o_valid),
        .i_rsp_stall     (i_stall),
        .i_rsp_character (o_character),
        .i_rsp_last_char (o_last_char),
        .o_errors        (errors),
        .o_pending       (pending),
        .o_chars_checked (chars_checked)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        cycles = 0;
        while (cycles < CYC_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d characters still expected", cycles, pending);
        $display("signed_binary_to_decimal_ascii_top test failed");
        $finish;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : int'($urandom_range(0, 9));
    endfunction

    // Present one value request and hold it until accepted; ends on a falling edge
    task automatic send_value(input logic signed [VW-1:0] v);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        n_sent++;
        if (v[VW-1]) n_neg++;
        if (v == 0)  n_zero++;
        @(negedge i_clk);
    endtask

    // Hold off new requests until every expected character has come out
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    // Random value: full range, small numbers, decade edges, range extremes
    function automatic logic signed [VW-1:0] random_value();
        longint p;
        longint m;
        case ($urandom_range(0, 4))
            0, 1: m = longint'($signed($urandom()));
            2: m = longint'($urandom_range(0, 999));
            3: begin
                p = 1;
                repeat ($urandom_range(0, 9)) p = p * 10;
                m = p - 1 + longint'($urandom_range(0, 2));
            end
            default: m = 64'sd2147483647 - longint'($urandom_range(0, 3));
        endcase
        if ($urandom_range(0, 1)) m = -m - longint'($urandom_range(0, 1));
        return VW'(m);
    endfunction

    // Character receiver: random stall before each character request
    initial begin
        int gap;
        i_stall = 1'b1;
        @(negedge i_clk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // Stimulus and verdict
    initial begin
        logic signed [VW-1:0] directed [0:21];
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_value = '0;
        n_sent  = 0;
        n_neg   = 0;
        n_zero  = 0;
        no_idle = 1'b0;
        directed = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100,
                     2147483647, -2147483647, 32'sh8000_0000,
                     999999999, -999999999, 1000000000, -1000000000,
                     1999999999, 12345, -12345, 32'sh5555_5555, 32'shAAAA_AAAA};
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: zero, single digits, decade edges, both range extremes
        foreach (directed[i]) send_value(directed[i]);
        wait_drained();

        // Random, with back-to-back stretches and a few full drains
        for (int n = 0; n < N_RANDOM; n++) begin
            if ($urandom_range(0, 29) == 0) no_idle = !no_idle;
            if (n == 120 || n == 240) wait_drained();
            send_value(random_value());
        end
        i_valid <= 1'b0;
        no_idle = 1'b0;

        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYC) @(negedge i_clk);

        $display("converted %0d values (%0d negative, %0d zero), %0d characters checked",
                 n_sent, n_neg, n_zero, chars_checked);
        $display("run took %0d cycles with random idle and stall gaps", cycles);
        if (errors == 0) begin
            $display("signed_binary_to_decimal_ascii_top test passed");
        end else begin
            $display("%0d mismatches", errors);
            $display("signed_binary_to_decimal_ascii_top test failed");
        end
        $finish;
    end

endmodule
